@@ rtl/core/sor_poisson_grid_solver_defines.svh @@
// Assertion macros for the SOR grid solver checkers.
`ifndef SOR_POISSON_GRID_SOLVER_DEFINES_SVH
`define SOR_POISSON_GRID_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sor assertion failed");

// Next-cycle implication, disabled during reset.
`define SOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sor assertion failed");

`endif

@@ rtl/core/sor_pkg.sv @@
// Types and constants shared by the SOR grid solver modules.
`default_nettype none

package sor_pkg;

    localparam int ERR_W   = 48;
    localparam int CNT_W   = 17;
    localparam int RES_W   = 36;
    localparam int PROD_W  = 53;
    localparam int ALU_W   = 54;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_SOLVE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd2;

    localparam logic [15:0]      OMEGA_RST      = 16'd31234;
    localparam logic [ERR_W-1:0] THRESHOLD_RST  = 48'd1;
    localparam logic [15:0]      MAX_SWEEPS_RST = 16'd1000;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
    localparam logic [31:0]      S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]      S32_MIN = 32'h8000_0000;
    localparam logic [ALU_W-1:0] ROUND_HALF = 54'd32768;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] u_in;
        logic signed [31:0] f_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] u_out;
        logic [CNT_W-1:0]   sweeps_done;
        logic [ERR_W-1:0]   final_error;
        logic               converged;
    } rsp_t;

    typedef struct packed {
        logic zero_a;
        logic sub;
    } alu_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/sor_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sor_alu.sv @@
// Shared adder/subtractor and relaxation multiplier of the SOR solver.
`default_nettype none

module sor_alu (
    input  wire sor_pkg::alu_ctrl_t                  ctrl,
    input  wire logic signed [sor_pkg::ALU_W-1:0]    a,
    input  wire logic signed [sor_pkg::ALU_W-1:0]    b,
    output logic signed      [sor_pkg::ALU_W-1:0]    sum,
    input  wire logic        [15:0]                  omega,
    input  wire logic signed [sor_pkg::RES_W-1:0]    res,
    output logic signed      [sor_pkg::PROD_W-1:0]   prod
);

    import sor_pkg::*;

    logic [ALU_W-1:0] a_eff;
    logic [ALU_W-1:0] b_eff;

    assign a_eff = ctrl.zero_a ? '0 : a;
    assign b_eff = ctrl.sub ? ~b : b;
    assign sum   = $signed(a_eff + b_eff + {{(ALU_W-1){1'b0}}, ctrl.sub});

    assign prod = $signed({1'b0, omega}) * res;

endmodule

`default_nettype wire

@@ rtl/core/sor_poisson_grid_solver.sv @@
// SOR Poisson solver top level: sequencer, grid memories and result register.
// Solve: each sweep visits every interior site, which is worked through the single
//   U memory read port and the shared adder.
// One request is worked at a time; the next is taken while a result waits.
// Reset clears control and sweep state and sets the config registers to their defaults; grid contents are undefined.
`default_nettype none

module sor_poisson_grid_solver #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire sor_pkg::req_t                   req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output sor_pkg::rsp_t                        rsp_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sor_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sor_pkg::ERR_W-1:0]       cfg_data
);

    import sor_pkg::*;

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int ADDR_W = RW + CW;
    localparam int DEPTH  = 1 << ADDR_W;

    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_READ      = 15'b000000000000010,
        ST_RD_UP     = 15'b000000000000100,
        ST_RD_DN     = 15'b000000000001000,
        ST_RD_LT     = 15'b000000000010000,
        ST_RD_RT     = 15'b000000000100000,
        ST_RD_CTR    = 15'b000000001000000,
        ST_SUB_U     = 15'b000000010000000,
        ST_SUB_F     = 15'b000000100000000,
        ST_MAG       = 15'b000001000000000,
        ST_ERR       = 15'b000010000000000,
        ST_ROUND     = 15'b000100000000000,
        ST_UPDATE    = 15'b001000000000000,
        ST_SWEEP_END = 15'b010000000000000,
        ST_DONE      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [ERR_W-1:0] err_reg, err_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic inside_reg, inside_next;
    logic [15:0] omega_reg;
    logic [ERR_W-1:0] thr_reg;
    logic [15:0] max_reg;
    logic out_valid_reg;

    logic signed [ALU_W-1:0] acc_reg, acc_next;
    logic [31:0] uc_reg, uc_next;
    logic [RES_W-1:0] mag_reg, mag_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ALU_W-17:0] rnd_reg, rnd_next;
    rsp_t res_reg, res_next;
    rsp_t out_reg;

    logic req_accept;
    logic req_inside;
    logic out_load;
    logic [ADDR_W-1:0] req_addr;
    logic [ADDR_W-1:0] ctr_addr;
    logic [RW-1:0] row_up;
    logic [RW-1:0] row_dn;
    logic [CW-1:0] col_lt;
    logic [CW-1:0] col_rt;

    logic u_wr_en, f_wr_en, u_rd_en, f_rd_en;
    logic [ADDR_W-1:0] u_wr_addr, u_rd_addr;
    logic [31:0] u_wr_data;
    logic [31:0] u_rd_data, f_rd_data;

    alu_ctrl_t alu_ctrl;
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic signed [PROD_W-1:0] mul_prod;

    logic [31:0] sat_u;
    logic [ERR_W-1:0] sat_err;
    logic [CNT_W-1:0] count_inc;
    logic sweep_again;

    assign req_stall  = !(state_reg == ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = out_valid_reg;
    assign rsp_data   = out_reg;

    assign req_inside = (32'(req_data.row) < 32'(ROWS)) && (32'(req_data.col) < 32'(COLS));
    assign req_addr   = {RW'(req_data.row), CW'(req_data.col)};
    assign ctr_addr   = {row_reg, col_reg};
    assign row_up     = row_reg + RW'(1);
    assign row_dn     = row_reg - RW'(1);
    assign col_lt     = col_reg - CW'(1);
    assign col_rt     = col_reg + CW'(1);

    assign sat_u = ((&alu_sum[ALU_W-1:31]) || !(|alu_sum[ALU_W-1:31])) ? alu_sum[31:0]
                 : (alu_sum[ALU_W-1] ? S32_MIN : S32_MAX);
    assign sat_err = (|alu_sum[ALU_W-1:ERR_W]) ? ERR_MAX : alu_sum[ERR_W-1:0];

    assign count_inc   = count_reg + CNT_W'(1);
    assign sweep_again = (err_reg > thr_reg) && (count_inc <= {1'b0, max_reg});

    sor_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid_u (
        .clk     (clk),
        .wr_en   (u_wr_en),
        .wr_addr (u_wr_addr),
        .wr_data (u_wr_data),
        .rd_en   (u_rd_en),
        .rd_addr (u_rd_addr),
        .rd_data (u_rd_data)
    );

    sor_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid_f (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (req_addr),
        .wr_data (req_data.f_in),
        .rd_en   (f_rd_en),
        .rd_addr (ctr_addr),
        .rd_data (f_rd_data)
    );

    sor_alu u_alu (
        .ctrl  (alu_ctrl),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .omega (omega_reg),
        .res   (acc_reg[RES_W-1:0]),
        .prod  (mul_prod)
    );

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        err_next    = err_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        acc_next    = acc_reg;
        uc_next     = uc_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        rnd_next    = rnd_reg;
        res_next    = res_reg;
        out_load    = 1'b0;
        u_wr_en     = 1'b0;
        f_wr_en     = 1'b0;
        u_wr_addr   = ctr_addr;
        u_wr_data   = sat_u;
        u_rd_en     = 1'b0;
        u_rd_addr   = ctr_addr;
        f_rd_en     = 1'b0;
        alu_ctrl    = '0;
        alu_a       = acc_reg;
        alu_b       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    res_next    = '0;
                    inside_next = req_inside;
                    unique case (req_data.req_type)
                        REQ_WRITE:
                        begin
                            u_wr_en    = req_inside;
                            f_wr_en    = req_inside;
                            u_wr_addr  = req_addr;
                            u_wr_data  = req_data.u_in;
                            state_next = ST_DONE;
                        end
                        REQ_SOLVE:
                        begin
                            err_next   = '0;
                            count_next = '0;
                            row_next   = RW'(ROWS - 2);
                            col_next   = CW'(1);
                            state_next = ST_RD_UP;
                        end
                        REQ_READ:
                        begin
                            u_rd_en    = 1'b1;
                            u_rd_addr  = req_addr;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.u_out = inside_reg ? u_rd_data : '0;
                state_next     = ST_DONE;
            end
            ST_RD_UP:
            begin
                u_rd_en    = 1'b1;
                u_rd_addr  = {row_up, col_reg};
                f_rd_en    = 1'b1;
                state_next = ST_RD_DN;
            end
            ST_RD_DN:
            begin
                u_rd_en         = 1'b1;
                u_rd_addr       = {row_dn, col_reg};
                alu_ctrl.zero_a = 1'b1;
                alu_b           = ALU_W'($signed(u_rd_data));
                acc_next        = alu_sum;
                state_next      = ST_RD_LT;
            end
            ST_RD_LT:
            begin
                u_rd_en    = 1'b1;
                u_rd_addr  = {row_reg, col_lt};
                alu_b      = ALU_W'($signed(u_rd_data));
                acc_next   = alu_sum;
                state_next = ST_RD_RT;
            end
            ST_RD_RT:
            begin
                u_rd_en    = 1'b1;
                u_rd_addr  = {row_reg, col_rt};
                alu_b      = ALU_W'($signed(u_rd_data));
                acc_next   = alu_sum;
                state_next = ST_RD_CTR;
            end
            ST_RD_CTR:
            begin
                u_rd_en    = 1'b1;
                u_rd_addr  = ctr_addr;
                alu_b      = ALU_W'($signed(u_rd_data));
                acc_next   = alu_sum;
                state_next = ST_SUB_U;
            end
            ST_SUB_U:
            begin
                alu_ctrl.sub = 1'b1;
                alu_b        = ALU_W'($signed({u_rd_data, 2'b00}));
                acc_next     = alu_sum;
                uc_next      = u_rd_data;
                state_next   = ST_SUB_F;
            end
            ST_SUB_F:
            begin
                alu_ctrl.sub = 1'b1;
                alu_b        = ALU_W'($signed(f_rd_data));
                acc_next     = alu_sum;
                state_next   = ST_MAG;
            end
            ST_MAG:
            begin
                alu_ctrl.zero_a = 1'b1;
                alu_ctrl.sub    = acc_reg[ALU_W-1];
                alu_b           = acc_reg;
                mag_next        = alu_sum[RES_W-1:0];
                prod_next       = mul_prod;
                state_next      = ST_ERR;
            end
            ST_ERR:
            begin
                alu_a      = $signed({{(ALU_W-ERR_W){1'b0}}, err_reg});
                alu_b      = $signed({{(ALU_W-RES_W){1'b0}}, mag_reg});
                err_next   = sat_err;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                alu_a      = ALU_W'(prod_reg);
                alu_b      = $signed(ROUND_HALF);
                rnd_next   = alu_sum[ALU_W-1:16];
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                alu_a   = ALU_W'($signed(uc_reg));
                alu_b   = ALU_W'(rnd_reg);
                u_wr_en = 1'b1;
                if (col_reg == CW'(COLS - 2))
                begin
                    col_next = CW'(1);
                    if (row_reg == RW'(1))
                    begin
                        state_next = ST_SWEEP_END;
                    end
                    else
                    begin
                        row_next   = row_dn;
                        state_next = ST_RD_UP;
                    end
                end
                else
                begin
                    col_next   = col_rt;
                    state_next = ST_RD_UP;
                end
            end
            ST_SWEEP_END:
            begin
                count_next = count_inc;
                if (sweep_again)
                begin
                    err_next   = '0;
                    row_next   = RW'(ROWS - 2);
                    col_next   = CW'(1);
                    state_next = ST_RD_UP;
                end
                else
                begin
                    res_next.sweeps_done = count_inc;
                    res_next.final_error = err_reg;
                    res_next.converged   = (err_reg <= thr_reg);
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            err_reg       <= '0;
            count_reg     <= '0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            omega_reg     <= OMEGA_RST;
            thr_reg       <= THRESHOLD_RST;
            max_reg       <= MAX_SWEEPS_RST;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            err_reg    <= err_next;
            count_reg  <= count_next;
            inside_reg <= inside_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OMEGA:      omega_reg <= cfg_data[15:0];
                    CFG_THRESHOLD:  thr_reg   <= cfg_data;
                    CFG_MAX_SWEEPS: max_reg   <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        uc_reg   <= uc_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sor_checker.sv @@
// Port-level assertion checker for the SOR grid solver, bound to the top level.
`default_nettype none

`include "sor_poisson_grid_solver_defines.svh"

module sor_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire sor_pkg::req_t req_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire sor_pkg::rsp_t rsp_data
);

    import sor_pkg::*;

    `SOR_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `SOR_ASSERT_NXT(a_rsp_stable, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp_data))
    `SOR_ASSERT_NXT(a_solve_busy, clk, rst_n, req_valid && !req_stall && req_data.req_type == REQ_SOLVE, req_stall)
    `SOR_ASSERT_IMP(a_read_only, clk, rst_n, rsp_valid && rsp_data.u_out != 0, rsp_data.sweeps_done == 0 && !rsp_data.converged)
    `SOR_ASSERT_IMP(a_conv_sweeps, clk, rst_n, rsp_valid && rsp_data.converged, rsp_data.sweeps_done != 0)

endmodule

bind sor_poisson_grid_solver sor_checker u_checker (.*);

`default_nettype wire

@@ dv/tb_sor_poisson_grid_solver.sv @@
// Testbench for the SOR Poisson grid solver: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_sor_poisson_grid_solver;
    import sor_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_PAD = 20;
    localparam int PRINT_CAP = 50;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam rsp_t ZERO_RSP = '0;

    typedef struct {
        bit                 reconfig;
        logic [15:0]        omega;
        logic [ERR_W-1:0]   thr;
        logic [15:0]        max_sw;
        req_t               req;
        bit                 typed;
        rsp_t               rsp;
    } stim_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req_data = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ERR_W-1:0] cfg_data = '0;

    logic signed [31:0] grid_u [0:ROWS*COLS-1];
    logic signed [31:0] grid_f [0:ROWS*COLS-1];
    logic [15:0]        omega_q = OMEGA_RST;
    logic [ERR_W-1:0]   thr_q = THRESHOLD_RST;
    logic [15:0]        max_sweeps_q = MAX_SWEEPS_RST;

    rsp_t      awaited_results [$];
    stim_row_t directed [$];
    int        err_count = 0;
    int        result_count = 0;
    int        idle_cycles = 0;
    bit        bursts_on = 1'b1;
    int        stall_left = 0;

    sor_poisson_grid_solver #(.ROWS(ROWS), .COLS(COLS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t mk_req(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                                    logic [31:0] u, logic [31:0] f);
        req_t r;
        r.req_type = kind;
        r.row      = row;
        r.col      = col;
        r.u_in     = u;
        r.f_in     = f;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [31:0] u, logic [CNT_W-1:0] sweeps,
                                    logic [ERR_W-1:0] err, logic conv);
        rsp_t r;
        r.u_out       = u;
        r.sweeps_done = sweeps;
        r.final_error = err;
        r.converged   = conv;
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 2097152) - 32'd1048576;
    endfunction

    function automatic req_t rand_req();
        int          sel;
        logic [1:0]  kind;
        sel = $urandom_range(0, 19);
        kind = (sel < 11) ? REQ_WRITE : (sel < 19) ? REQ_READ : REQ_UNKNOWN;
        return mk_req(kind, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      rand_value(), rand_value());
    endfunction

    // One in-place relaxation pass; returns the saturated residual magnitude sum.
    function automatic logic [ERR_W-1:0] relax_sweep();
        longint res;
        longint mag;
        longint delta;
        longint nu;
        longint acc;
        longint err_cap;
        int     idx;
        int     r;
        int     c;
        acc = 0;
        err_cap = longint'(ERR_MAX);
        for (r = ROWS - 2; r >= 1; r--)
        begin
            for (c = 1; c <= COLS - 2; c++)
            begin
                idx = r * COLS + c;
                res = longint'(grid_u[idx + COLS]) + longint'(grid_u[idx - COLS])
                    + longint'(grid_u[idx - 1]) + longint'(grid_u[idx + 1])
                    - 4 * longint'(grid_u[idx]) - longint'(grid_f[idx]);
                mag = (res < 0) ? -res : res;
                delta = (longint'(omega_q) * res + 64'sd32768) >>> 16;
                nu = longint'(grid_u[idx]) + delta;
                if (nu > 64'sd2147483647)
                    grid_u[idx] = S32_MAX;
                else if (nu < -64'sd2147483648)
                    grid_u[idx] = S32_MIN;
                else
                    grid_u[idx] = nu[31:0];
                acc = (err_cap - acc < mag) ? err_cap : acc + mag;
            end
        end
        return acc[ERR_W-1:0];
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t             out;
        int               idx;
        int               cnt;
        logic [ERR_W-1:0] err;
        out = '0;
        idx = int'(r.row) * COLS + int'(r.col);
        case (r.req_type)
            REQ_WRITE:
            begin
                grid_u[idx] = r.u_in;
                grid_f[idx] = r.f_in;
            end
            REQ_SOLVE:
            begin
                cnt = 0;
                do
                begin
                    err = relax_sweep();
                    cnt++;
                end
                while (err > thr_q && cnt <= int'(max_sweeps_q));
                out.sweeps_done = cnt[CNT_W-1:0];
                out.final_error = err;
                out.converged   = (err <= thr_q);
            end
            REQ_READ:
                out.u_out = grid_u[idx];
            default:
                out = '0;
        endcase
        return out;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        begin
            err_count++;
            if (err_count <= PRINT_CAP)
                $display("ERROR result %0d %s: got 0x%0h, want 0x%0h",
                         result_count, what, got, want);
        end
    endtask

    task automatic drive_req(input req_t r, input bit typed, input rsp_t given);
        int   gap;
        rsp_t predicted;
        begin
            gap = (bursts_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            req_valid <= 1'b1;
            req_data  <= r;
            do @(posedge clk); while (req_stall);
            predicted = apply_request(r);
            awaited_results.push_back(typed ? given : predicted);
        end
    endtask

    task automatic drain_results();
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            while (awaited_results.size() != 0) @(posedge clk);
            repeat (DRAIN_PAD) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ERR_W-1:0] val);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                CFG_OMEGA:      omega_q = val[15:0];
                CFG_THRESHOLD:  thr_q = val;
                CFG_MAX_SWEEPS: max_sweeps_q = val[15:0];
                default:        ;
            endcase
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic program_regs(input logic [15:0] om, input logic [ERR_W-1:0] thr,
                                input logic [15:0] max_sw);
        begin
            write_reg(CFG_OMEGA, {32'd0, om});
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_MAX_SWEEPS, {32'd0, max_sw});
        end
    endtask

    task automatic run_random_phase(input int n_items);
        int solve_at;
        int i;
        begin
            solve_at = $urandom_range(0, n_items - 1);
            for (i = 0; i < n_items; i++)
            begin
                if (i == solve_at)
                    drive_req(mk_req(REQ_SOLVE, 6'($urandom_range(0, 63)),
                                     6'($urandom_range(0, 63)), $urandom, $urandom),
                              1'b0, ZERO_RSP);
                else
                    drive_req(rand_req(), 1'b0, ZERO_RSP);
            end
        end
    endtask

    // Response backpressure in random bursts.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!bursts_on)
            begin
                stall_left = 0;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (rsp_valid && !rsp_stall)
            begin
                result_count++;
                if (awaited_results.size() == 0)
                    report_mismatch("transaction with none awaited",
                                    64'(rsp_data.u_out), 64'd0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_data.u_out !== want.u_out)
                        report_mismatch("u_out", 64'(rsp_data.u_out), 64'(want.u_out));
                    if (rsp_data.sweeps_done !== want.sweeps_done)
                        report_mismatch("sweeps_done", 64'(rsp_data.sweeps_done),
                                        64'(want.sweeps_done));
                    if (rsp_data.final_error !== want.final_error)
                        report_mismatch("final_error", 64'(rsp_data.final_error),
                                        64'(want.final_error));
                    if (rsp_data.converged !== want.converged)
                        report_mismatch("converged", 64'(rsp_data.converged),
                                        64'(want.converged));
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int r;
        int c;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clear every site so no sweep touches an unwritten entry
        for (r = 0; r < ROWS; r++)
            for (c = 0; c < COLS; c++)
                drive_req(mk_req(REQ_WRITE, 6'(r), 6'(c), 32'd0, 32'd0), 1'b0, ZERO_RSP);

        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd0, 6'd0, 32'd0, 32'd0), 1'b1, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_SOLVE, 6'd0, 6'd0, 32'd0, 32'd0), 1'b1,
            mk_rsp(32'd0, 17'd1, 48'd0, 1'b1)});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd0, 6'd0, S32_MAX, S32_MIN), 1'b1, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd63, 6'd63, S32_MIN, S32_MAX), 1'b1, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd0, 6'd0, 32'd0, 32'd0), 1'b1,
            mk_rsp(S32_MAX, 17'd0, 48'd0, 1'b0)});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd63, 6'd63, 32'd0, 32'd0), 1'b1,
            mk_rsp(S32_MIN, 17'd0, 48'd0, 1'b0)});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_UNKNOWN, 6'h3F, 6'h3F, '1, '1), 1'b1, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd1, 6'd1, 32'h0001_0000, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd32, 6'd17, 32'hFFFB_0000, 32'h0003_0000), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd62, 6'd62, S32_MAX, S32_MIN), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd1, 6'd62, S32_MIN, S32_MAX), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd0, 6'd31, S32_MAX, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_WRITE, 6'd63, 6'd5, S32_MIN, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b1, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_SOLVE, 6'd0, 6'd0, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd1, 6'd1, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b1, 16'hFFFF, ERR_MAX, 16'hFFFF,
            mk_req(REQ_SOLVE, 6'h3F, 6'h3F, '1, '1), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd62, 6'd62, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd1, 6'd62, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b1, 16'd32768, 48'd0, 16'd1,
            mk_req(REQ_SOLVE, 6'd0, 6'd0, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd32, 6'd17, 32'd0, 32'd0), 1'b0, ZERO_RSP});
        directed.push_back('{1'b0, 16'd0, 48'd0, 16'd0,
            mk_req(REQ_READ, 6'd31, 6'd17, 32'd0, 32'd0), 1'b0, ZERO_RSP});

        foreach (directed[i])
        begin
            if (directed[i].reconfig)
            begin
                drain_results();
                program_regs(directed[i].omega, directed[i].thr, directed[i].max_sw);
            end
            drive_req(directed[i].req, directed[i].typed, directed[i].rsp);
        end

        drain_results();
        program_regs(OMEGA_RST, 48'({$urandom, $urandom}), 16'd0);
        run_random_phase(47);

        drain_results();
        program_regs(16'($urandom_range(0, 32768)), ERR_MAX, 16'($urandom_range(0, 65535)));
        run_random_phase(47);

        drain_results();
        bursts_on = 1'b0;
        program_regs(16'($urandom_range(0, 65535)), 48'd0, 16'd1);
        run_random_phase(47);

        drain_results();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
